/* src/fcv_pkg.sv */
// fcv_pkg: shared constants, codes and helpers for the fletcher checksum verifier
`default_nettype none

package fcv_pkg;

	localparam int MAX_BLOCK_BITS = 32;
	localparam int SUM_W          = MAX_BLOCK_BITS;
	localparam int VAL_W          = 64;
	localparam int CFG_W          = 6;
	localparam int IN_DATA_W      = ((VAL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W     = ((VAL_W + 1 + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] BLOCK_BITS_RST = CFG_W'(8);

	typedef enum logic {
		REQ_DATA  = 1'b0,
		REQ_CHECK = 1'b1
	} req_type_t;

	// clamp the configured width into 1 .. MAX_BLOCK_BITS
	function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] bits);
		logic [CFG_W-1:0] k;
		k = bits;
		if (k == '0) begin
			k = CFG_W'(1);
		end else if (k > CFG_W'(MAX_BLOCK_BITS)) begin
			k = CFG_W'(MAX_BLOCK_BITS);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

/* src/fletcher_checksum_verifier.sv */
// fletcher_checksum_verifier: receiver-side fletcher check with block width 1 to 32 bits
//
// channel   dir  tdata (low bit up)                      tuser
// s_axis    in   item_value[63:0]                        req_type
// m_axis    out  checksum_ok, computed_checksum[63:0]    -
// cfg       in   block_bits[5:0] on cfg_wdata, cfg_wen   -
//
// one beat per cycle when no fold or output stall holds it: input register, two
// end-around adds, then the sum registers; a closing beat goes on to the output
// register once the output is free; after a width cut inside a frame the next
// data beat waits while both sums are folded down, one fold per cycle
// arst_n clears the sums, the valid flags and sets the width to 8
// a stalled output blocks only closing beats; a data beat in the input register still advances
`default_nettype none

module fletcher_checksum_verifier (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [fcv_pkg::CFG_W-1:0]      cfg_wdata,      // block_bits
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [fcv_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // item_value
	input  wire logic                           s_axis_tuser,   // req_type
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [fcv_pkg::OUT_DATA_W-1:0]      m_axis_tdata    // checksum_ok, computed_checksum
);

	import fcv_pkg::*;

	logic [CFG_W-1:0] bits_q;
	logic [CFG_W-1:0] k;
	logic [SUM_W-1:0] modulus;

	logic             valid_s1;
	req_type_t        type_s1;
	logic [VAL_W-1:0] value_s1;

	logic [SUM_W-1:0] low_q;
	logic [SUM_W-1:0] high_q;

	logic             out_valid_q;
	logic             ok_q;
	logic [VAL_W-1:0] computed_q;

	logic             stale;
	logic             out_free;
	logic             advance;
	logic             reduce;
	logic [SUM_W:0]   low_add;
	logic [SUM_W-1:0] low_next;
	logic [SUM_W:0]   high_add;
	logic [SUM_W-1:0] high_next;
	logic [SUM_W-1:0] low_fold;
	logic [SUM_W-1:0] high_fold;
	logic [VAL_W-1:0] computed;
	logic [VAL_W-1:0] received;

	assign k       = eff_width(bits_q);
	assign modulus = SUM_W'(({{SUM_W{1'b0}}, 1'b1} << k) - 1'b1);

	// sums left over from a wider block width
	assign stale    = (low_q >= modulus) || (high_q >= modulus);
	assign out_free = !out_valid_q || m_axis_tready;
	assign advance  = valid_s1 && ((type_s1 == REQ_CHECK) ? out_free : !stale);
	assign reduce   = valid_s1 && (type_s1 == REQ_DATA) && stale;

	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		low_add = {1'b0, low_q} + {1'b0, value_s1[SUM_W-1:0] & modulus};
		if (low_add >= {1'b0, modulus}) begin
			low_add = low_add - {1'b0, modulus};
		end
		low_next = low_add[SUM_W-1:0];

		high_add = {1'b0, high_q} + {1'b0, low_next};
		if (high_add >= {1'b0, modulus}) begin
			high_add = high_add - {1'b0, modulus};
		end
		high_next = high_add[SUM_W-1:0];
	end

	// one fold of a 2^k-1 residue: low k bits plus the rest shifted down
	always_comb begin
		if (low_q == modulus) begin
			low_fold = '0;
		end else begin
			low_fold = (low_q & modulus) + (low_q >> k);
		end
		if (high_q == modulus) begin
			high_fold = '0;
		end else begin
			high_fold = (high_q & modulus) + (high_q >> k);
		end
	end

	assign computed = ({{(VAL_W-SUM_W){1'b0}}, high_q} << k) | {{(VAL_W-SUM_W){1'b0}}, low_q};
	assign received = value_s1 & ~({VAL_W{1'b1}} << {k, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BLOCK_BITS_RST;
		end else if (cfg_wen) begin
			bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			type_s1  <= req_type_t'(s_axis_tuser);
			value_s1 <= s_axis_tdata[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (advance) begin
			if (type_s1 == REQ_CHECK) begin
				low_q  <= '0;
				high_q <= '0;
			end else begin
				low_q  <= low_next;
				high_q <= high_next;
			end
		end else if (reduce) begin
			low_q  <= low_fold;
			high_q <= high_fold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (type_s1 == REQ_CHECK)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (type_s1 == REQ_CHECK)) begin
			ok_q       <= (computed == received);
			computed_q <= computed;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-VAL_W-1){1'b0}}, computed_q, ok_q};

	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (type_s1 == REQ_DATA) |=>
			(low_q < $past(modulus)) && (high_q < $past(modulus)))
		else $error("sums not reduced below modulus after a data beat");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (type_s1 == REQ_CHECK) |=> (low_q == '0) && (high_q == '0))
		else $error("sums not cleared after a closing beat");

	a_out_from_close: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && (type_s1 == REQ_CHECK)))
		else $error("output beat without a closing beat");

	a_no_stall_fold: assert property (@(posedge clk) disable iff (!arst_n)
		reduce |-> !advance && valid_s1)
		else $error("fold and accept in the same cycle");

endmodule

`default_nettype wire

/* dv/tb.sv */
// tb: stream-driven self-checking bench for the fletcher checksum verifier
`default_nettype none

module tb;
	import fcv_pkg::*;

	localparam int SETTLE_CYCLES = 48;
	localparam int RANDOM_ITEMS  = 500;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_DATA,
		ROW_CHECK
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [63:0] value;
		bit          typed;
		bit          ok;
		logic [63:0] sum;
	} plan_row_t;

	typedef struct {
		bit          ok;
		logic [63:0] sum;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // item_value
	logic                  s_axis_tuser;   // req_type
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // checksum_ok, computed_checksum

	// bench copy of the block state
	logic [CFG_W-1:0] width_cfg;
	logic [31:0]      low_acc;
	logic [31:0]      high_acc;

	verdict_t verdict_q[$];
	verdict_t got;
	int       errors;
	int       items_sent;
	int       sink_hold;
	bit       calm;

	plan_row_t plan [0:26] = '{
		'{ROW_CHECK, 64'h0,                   1'b1, 1'b1, 64'h0},
		'{ROW_DATA,  64'hFF,                  1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h0,                   1'b1, 1'b1, 64'h0},
		'{ROW_DATA,  64'hFFFF_FFFF_FFFF_FF01, 1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'h02,                  1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'hFFFF_FFFF_FFFF_0403, 1'b1, 1'b1, 64'h0403},
		'{ROW_DATA,  64'h10,                  1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h0,                   1'b1, 1'b0, 64'h1010},
		'{ROW_CFG,   64'd0,                   1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'h1,                   1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h0,                   1'b1, 1'b1, 64'h0},
		'{ROW_CFG,   64'd32,                  1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'hFFFF_FFFF,           1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'hFFFF_FFFE_FFFF_FFFE},
		'{ROW_CFG,   64'd63,                  1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'h8000_0000,           1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'h7FFF_FFFF,           1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
		'{ROW_DATA,  64'h1234_5678,           1'b0, 1'b0, 64'h0},
		'{ROW_CFG,   64'd4,                   1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h0,                   1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'h9876_5432,           1'b0, 1'b0, 64'h0},
		'{ROW_CFG,   64'd20,                  1'b0, 1'b0, 64'h0},
		'{ROW_DATA,  64'hF_FFFE,              1'b0, 1'b0, 64'h0},
		'{ROW_CHECK, 64'h0,                   1'b0, 1'b0, 64'h0}
	};

	fletcher_checksum_verifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int block_width();
		if (width_cfg == '0) begin
			return 1;
		end else if (width_cfg > CFG_W'(MAX_BLOCK_BITS)) begin
			return MAX_BLOCK_BITS;
		end
		return int'(width_cfg);
	endfunction

	function automatic logic [63:0] ones(int bits);
		if (bits >= 64) begin
			return '1;
		end
		return (64'd1 << bits) - 64'd1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// advance the bench state by one beat, returns the verdict of a closing beat
	function automatic verdict_t fold_beat(req_type_t req, logic [63:0] value);
		verdict_t    v;
		int          k;
		logic [63:0] modulus;
		logic [63:0] low_next;
		k       = block_width();
		modulus = ones(k);
		v.ok    = 1'b0;
		v.sum   = '0;
		if (req == REQ_DATA) begin
			low_next = ({32'd0, low_acc} + (value & modulus)) % modulus;
			low_acc  = low_next[31:0];
			low_next = ({32'd0, high_acc} + low_next) % modulus;
			high_acc = low_next[31:0];
		end else begin
			v.sum    = ({32'd0, high_acc} << k) | {32'd0, low_acc};
			v.ok     = (v.sum == (value & ones(2 * k)));
			low_acc  = '0;
			high_acc = '0;
		end
		return v;
	endfunction

	task automatic send_item(req_type_t req, logic [63:0] value, bit typed, bit t_ok,
			logic [63:0] t_sum);
		int       gap;
		verdict_t v;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		v = fold_beat(req, value);
		if (req == REQ_CHECK) begin
			if (typed) begin
				v.ok  = t_ok;
				v.sum = t_sum;
			end
			verdict_q.push_back(v);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// stop the source and let the pipeline and any fold run dry
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_width(logic [CFG_W-1:0] bits);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= bits;
		width_cfg = bits;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_width();
		case ($urandom_range(0, 7))
			0: return CFG_W'(1);
			1: return CFG_W'(8);
			2: return CFG_W'(16);
			3: return CFG_W'(MAX_BLOCK_BITS);
			4: return '0;
			5: return '1;
			default: return CFG_W'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [63:0] pick_block();
		logic [63:0] modulus;
		modulus = ones(block_width());
		case ($urandom_range(0, 7))
			0: return '0;
			1: return modulus;
			2: return modulus - 64'd1;
			3, 4: return rand64();
			default: return rand64() & modulus;
		endcase
	endfunction

	function automatic logic [63:0] pick_closing();
		int          k;
		logic [63:0] correct;
		k       = block_width();
		correct = ({32'd0, high_acc} << k) | {32'd0, low_acc};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return correct | (rand64() & ~ones(2 * k));
			6, 7: return correct ^ (64'd1 << $urandom_range(0, 2 * k - 1));
			default: return rand64();
		endcase
	endfunction

	// result side: draw the next stall, then compare each beat
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sink_hold = calm ? 0 : $urandom_range(0, 19);
			if (verdict_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				got = verdict_q.pop_front();
				if (m_axis_tdata[0] !== got.ok) begin
					$display("%0t: checksum_ok expected %0d actual %0d", $time, got.ok,
						m_axis_tdata[0]);
					errors++;
				end
				if (m_axis_tdata[64:1] !== got.sum) begin
					$display("%0t: computed_checksum expected %h actual %h", $time, got.sum,
						m_axis_tdata[64:1]);
					errors++;
				end
				if (m_axis_tdata[OUT_DATA_W-1:65] !== '0) begin
					$display("%0t: tdata padding expected 0 actual %h", $time,
						m_axis_tdata[OUT_DATA_W-1:65]);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= (sink_hold == 0);
		if (sink_hold > 0) begin
			sink_hold--;
		end
	end

	initial begin
		int nblk;
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_DATA;
		m_axis_tready = 1'b1;
		width_cfg     = BLOCK_BITS_RST;
		low_acc       = '0;
		high_acc      = '0;
		errors        = 0;
		items_sent    = 0;
		sink_hold     = 0;
		calm          = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					set_width(plan[i].value[CFG_W-1:0]);
				end
				ROW_DATA: begin
					send_item(REQ_DATA, plan[i].value, 1'b0, 1'b0, '0);
				end
				default: begin
					send_item(REQ_CHECK, plan[i].value, plan[i].typed, plan[i].ok,
						plan[i].sum);
				end
			endcase
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			// every third stretch runs with no gaps on either side
			calm = ((items_sent / 60) % 3) == 2;
			if ($urandom_range(0, 3) == 0) begin
				set_width(pick_width());
			end
			nblk = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			for (int i = 0; i < nblk; i++) begin
				if (i > 0 && $urandom_range(0, 15) == 0) begin
					set_width(pick_width());
				end
				send_item(REQ_DATA, pick_block(), 1'b0, 1'b0, '0);
			end
			send_item(REQ_CHECK, pick_closing(), 1'b0, 1'b0, '0);
		end

		calm = 1'b0;
		settle();
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

/* fletcher_checksum_verifier.f */
src/fcv_pkg.sv
src/fletcher_checksum_verifier.sv
dv/tb.sv
